// ===== hw/rtl/sop_pkg.sv =====
// ============================================================================
// Security option parser package
// Shared types and constants for the option value parser.
// ============================================================================
package sop_pkg;

    // Parse position inside the option value
    typedef enum logic [3:0] {
        ST_FLAGS   = 4'd0,
        ST_FLAGS2  = 4'd1,
        ST_CORR    = 4'd2,
        ST_RX      = 4'd3,
        ST_TX      = 4'd4,
        ST_MID_LO  = 4'd5,
        ST_MID_HI  = 4'd6,
        ST_CTXLEN  = 4'd7,
        ST_CTX     = 4'd8,
        ST_TAIL    = 4'd9
    } t_stage;

    // Kind of byte streamed out with a result
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CTX  = 2'd1,
        KIND_KID  = 2'd2
    } t_byte_kind;

    // Bit positions in the flags byte and the second length byte
    localparam int unsigned FL_M_BIT = 6;
    localparam int unsigned FL_H_BIT = 5;
    localparam int unsigned FL_T_BIT = 4;
    localparam int unsigned FL_F_BIT = 3;
    localparam int unsigned FL_R_BIT = 6;

    typedef struct packed {
        t_byte_kind  byte_kind;
        logic [7:0]  out_byte;
        logic        done_res;
        logic        ok;
        logic        ts_present;
        logic        resync_request;
        logic [3:0]  phase;
        logic [63:0] corresponding_tx_time;
        logic [63:0] receive_time;
        logic [63:0] transmit_time;
        logic [15:0] e2e_id;
        logic [4:0]  context_length;
    } t_result;

endpackage

// ===== hw/rtl/sop_core.sv =====
// ============================================================================
// Security option parser core
// Parse state, field decode and result formation, one byte per cycle when i_step is high.
// ============================================================================
module sop_core #(
    parameter int unsigned MAX_STAMP_BYTES   = 7,
    parameter int unsigned MAX_KID_BYTES     = 7,
    parameter int unsigned MAX_CONTEXT_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_data_byte,
    input  logic             i_present,
    input  logic             i_last_byte,
    input  logic [15:0]      i_message_id,
    input  logic             i_is_request,
    output logic             o_res_valid,
    output sop_pkg::t_result o_res
);

    // Field from which a search for the next non-empty field starts
    localparam logic [2:0] FROM_CORR = 3'd0;
    localparam logic [2:0] FROM_RX   = 3'd1;
    localparam logic [2:0] FROM_TX   = 3'd2;
    localparam logic [2:0] FROM_MID  = 3'd3;
    localparam logic [2:0] FROM_CTX  = 3'd4;

    typedef struct packed {
        sop_pkg::t_stage stage;
        logic [4:0]      left;
        logic            fail;
    } t_seek;

    sop_pkg::t_stage r_stage, n_stage;
    logic [7:0]      r_flags, n_flags;
    logic [5:0]      r_lens, n_lens;
    logic [4:0]      r_left, n_left;
    logic [2:0]      r_shift, n_shift;
    logic [63:0]     r_corr, n_corr;
    logic [63:0]     r_rx, n_rx;
    logic [63:0]     r_tx, n_tx;
    logic [15:0]     r_id, n_id;
    logic [4:0]      r_ctx_len, n_ctx_len;
    logic [3:0]      r_kid_count, n_kid_count;
    logic            r_failed, n_failed;
    logic            r_resync, n_resync;
    logic            w_clear;
    logic [63:0]     w_lane;
    t_seek           w_seek;

    // Find the first field, from step k on, that still needs bytes
    function automatic t_seek seek(input logic [2:0] k, input logic [7:0] flags,
                                   input logic [5:0] lens);
        t_seek      s;
        logic       take_corr;
        logic       take_rx;
        logic       has_ts;
        s.stage   = sop_pkg::ST_TAIL;
        s.left    = '0;
        s.fail    = 1'b0;
        has_ts    = flags[sop_pkg::FL_T_BIT];
        take_corr = (k == FROM_CORR) && (lens[5:3] != 3'd0);
        take_rx   = (k <= FROM_RX) && (lens[2:0] != 3'd0);
        s.fail    = !take_corr && !take_rx && (k <= FROM_TX) && has_ts &&
                    ({1'b0, flags[2:0]} > 4'(MAX_STAMP_BYTES));
        priority if (take_corr) begin
            s.stage = sop_pkg::ST_CORR;
            s.left  = {2'b00, lens[5:3]};
        end else if (take_rx) begin
            s.stage = sop_pkg::ST_RX;
            s.left  = {2'b00, lens[2:0]};
        end else if ((k <= FROM_TX) && has_ts && (flags[2:0] != 3'd0)) begin
            s.stage = sop_pkg::ST_TX;
            s.left  = {2'b00, flags[2:0]};
        end else if ((k <= FROM_MID) && flags[sop_pkg::FL_M_BIT]) begin
            s.stage = sop_pkg::ST_MID_LO;
        end else if ((k <= FROM_CTX) && flags[sop_pkg::FL_H_BIT]) begin
            s.stage = sop_pkg::ST_CTXLEN;
        end else begin
            s.stage = sop_pkg::ST_TAIL;
        end
        return s;
    endfunction

    assign w_lane  = 64'(i_data_byte) << {r_shift, 3'b000};
    assign w_clear = !i_present || i_last_byte;

    // Next state after this byte, before the end-of-option clear
    always_comb begin
        n_stage     = r_stage;
        n_flags     = r_flags;
        n_lens      = r_lens;
        n_left      = r_left;
        n_shift     = r_shift;
        n_corr      = r_corr;
        n_rx        = r_rx;
        n_tx        = r_tx;
        n_id        = r_id;
        n_ctx_len   = r_ctx_len;
        n_kid_count = r_kid_count;
        n_failed    = r_failed;
        n_resync    = r_resync;
        w_seek      = '{stage: sop_pkg::ST_TAIL, left: '0, fail: 1'b0};
        if (i_present && !r_failed) begin
            unique case (r_stage)
                sop_pkg::ST_FLAGS: begin
                    n_flags = i_data_byte;
                    if (i_data_byte[sop_pkg::FL_T_BIT]) begin
                        if (i_data_byte[sop_pkg::FL_F_BIT]) begin
                            n_stage = sop_pkg::ST_FLAGS2;
                        end else begin
                            n_resync = 1'b1;
                            w_seek   = seek(FROM_TX, i_data_byte, r_lens);
                            n_stage  = w_seek.stage;
                            n_left   = w_seek.left;
                            n_shift  = '0;
                            n_failed = w_seek.fail;
                        end
                    end else begin
                        w_seek   = seek(FROM_MID, i_data_byte, r_lens);
                        n_stage  = w_seek.stage;
                        n_left   = w_seek.left;
                        n_shift  = '0;
                        n_failed = w_seek.fail;
                    end
                end
                sop_pkg::ST_FLAGS2: begin
                    n_resync = i_data_byte[sop_pkg::FL_R_BIT];
                    n_lens   = i_data_byte[5:0];
                    w_seek   = seek(FROM_CORR, r_flags, i_data_byte[5:0]);
                    n_stage  = w_seek.stage;
                    n_left   = w_seek.left;
                    n_shift  = '0;
                    n_failed = w_seek.fail ||
                               ({1'b0, i_data_byte[5:3]} > 4'(MAX_STAMP_BYTES)) ||
                               ({1'b0, i_data_byte[2:0]} > 4'(MAX_STAMP_BYTES));
                end
                sop_pkg::ST_CORR, sop_pkg::ST_RX, sop_pkg::ST_TX: begin
                    // Each byte lands in its own lane, so OR equals the add
                    unique case (r_stage)
                        sop_pkg::ST_CORR: n_corr = r_corr | w_lane;
                        sop_pkg::ST_RX:   n_rx   = r_rx | w_lane;
                        default:          n_tx   = r_tx | w_lane;
                    endcase
                    n_shift = r_shift + 3'd1;
                    n_left  = r_left - 5'd1;
                    if (n_left == 5'd0) begin
                        unique case (r_stage)
                            sop_pkg::ST_CORR: w_seek = seek(FROM_RX, r_flags, r_lens);
                            sop_pkg::ST_RX:   w_seek = seek(FROM_TX, r_flags, r_lens);
                            default:          w_seek = seek(FROM_MID, r_flags, r_lens);
                        endcase
                        n_stage  = w_seek.stage;
                        n_left   = w_seek.left;
                        n_shift  = '0;
                        n_failed = w_seek.fail;
                    end
                end
                sop_pkg::ST_MID_LO: begin
                    n_id    = {8'h00, i_data_byte};
                    n_stage = sop_pkg::ST_MID_HI;
                end
                sop_pkg::ST_MID_HI: begin
                    n_id     = {i_data_byte, r_id[7:0]};
                    w_seek   = seek(FROM_CTX, r_flags, r_lens);
                    n_stage  = w_seek.stage;
                    n_left   = w_seek.left;
                    n_shift  = '0;
                    n_failed = w_seek.fail;
                end
                sop_pkg::ST_CTXLEN: begin
                    if (i_data_byte > 8'(MAX_CONTEXT_BYTES)) begin
                        n_failed = 1'b1;
                    end else begin
                        n_ctx_len = i_data_byte[4:0];
                        if (i_data_byte[4:0] != 5'd0) begin
                            n_stage = sop_pkg::ST_CTX;
                            n_left  = i_data_byte[4:0];
                        end else begin
                            n_stage = sop_pkg::ST_TAIL;
                        end
                    end
                end
                sop_pkg::ST_CTX: begin
                    n_left = r_left - 5'd1;
                    if (n_left == 5'd0) begin
                        n_stage = sop_pkg::ST_TAIL;
                    end
                end
                sop_pkg::ST_TAIL: begin
                    if (i_is_request && (r_kid_count < 4'(MAX_KID_BYTES))) begin
                        n_kid_count = r_kid_count + 4'd1;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end
    end

    // Result of this byte: streamed byte and, at the end, the summary
    always_comb begin
        o_res           = '0;
        o_res.byte_kind = sop_pkg::KIND_NONE;
        if (i_present && !r_failed) begin
            if (r_stage == sop_pkg::ST_CTX) begin
                o_res.byte_kind = sop_pkg::KIND_CTX;
                o_res.out_byte  = i_data_byte;
            end else if (r_stage == sop_pkg::ST_TAIL && i_is_request &&
                         (r_kid_count < 4'(MAX_KID_BYTES))) begin
                o_res.byte_kind = sop_pkg::KIND_KID;
                o_res.out_byte  = i_data_byte;
            end
        end
        if (!i_present) begin
            o_res.done_res = 1'b1;
            o_res.ok       = 1'b1;
            o_res.e2e_id   = i_message_id;
        end else if (i_last_byte) begin
            o_res.done_res = 1'b1;
            if (!n_failed && n_stage == sop_pkg::ST_TAIL) begin
                o_res.ok             = 1'b1;
                o_res.ts_present     = n_flags[sop_pkg::FL_T_BIT];
                o_res.context_length = n_ctx_len;
                o_res.e2e_id         = n_flags[sop_pkg::FL_M_BIT] ? n_id : i_message_id;
                if (n_flags[sop_pkg::FL_T_BIT]) begin
                    o_res.resync_request        = n_resync;
                    o_res.corresponding_tx_time = n_corr;
                    o_res.receive_time          = n_rx;
                    o_res.transmit_time         = n_rx + n_tx;
                end else begin
                    o_res.phase = n_flags[3:0];
                end
            end
        end
        o_res_valid = (o_res.byte_kind != sop_pkg::KIND_NONE) || w_clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && w_clear)) begin
            r_stage     <= sop_pkg::ST_FLAGS;
            r_flags     <= '0;
            r_lens      <= '0;
            r_left      <= '0;
            r_shift     <= '0;
            r_corr      <= '0;
            r_rx        <= '0;
            r_tx        <= '0;
            r_id        <= '0;
            r_ctx_len   <= '0;
            r_kid_count <= '0;
            r_failed    <= 1'b0;
            r_resync    <= 1'b0;
        end else if (i_step) begin
            r_stage     <= n_stage;
            r_flags     <= n_flags;
            r_lens      <= n_lens;
            r_left      <= n_left;
            r_shift     <= n_shift;
            r_corr      <= n_corr;
            r_rx        <= n_rx;
            r_tx        <= n_tx;
            r_id        <= n_id;
            r_ctx_len   <= n_ctx_len;
            r_kid_count <= n_kid_count;
            r_failed    <= n_failed;
            r_resync    <= n_resync;
        end
    end

endmodule

// ===== hw/rtl/security_option_parser.sv =====
// ============================================================================
// Security option parser
// Parses one security option value a byte at a time and streams context and
// key identifier bytes, ending each option with a summary.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   input   | in        | i_valid / o_stall  | byte, present, last, id, req
//   result  | out       | o_valid / i_stall  | byte kind/value and summary
//
// One byte per cycle while the result side does not stall: a transfer lands in
// the input register, is decoded against the parse state in one pass and lands
// in the result register, and a new byte can follow every cycle.
// The input side stalls only while both registers hold an item and the
// result side stalls. Reset (synchronous) returns to expecting a flags byte.
// ============================================================================
module security_option_parser #(
    parameter int unsigned MAX_STAMP_BYTES   = 7,
    parameter int unsigned MAX_KID_BYTES     = 7,
    parameter int unsigned MAX_CONTEXT_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_present,
    input  logic        i_last_byte,
    input  logic [15:0] i_message_id,
    input  logic        i_is_request,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_byte_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_done_res,
    output logic        o_ok,
    output logic        o_ts_present,
    output logic        o_resync_request,
    output logic [3:0]  o_phase,
    output logic [63:0] o_corresponding_tx_time,
    output logic [63:0] o_receive_time,
    output logic [63:0] o_transmit_time,
    output logic [15:0] o_e2e_id,
    output logic [4:0]  o_context_length
);

    logic             r_in_valid;
    logic [7:0]       r_data_byte;
    logic             r_present;
    logic             r_last_byte;
    logic [15:0]      r_message_id;
    logic             r_is_request;
    logic             r_out_valid;
    sop_pkg::t_result r_res;
    sop_pkg::t_result w_res;
    logic             w_res_valid;
    logic             w_step;
    logic             w_accept;

    // Advance the held byte whenever the result register is free or draining
    assign w_step   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !w_step;
    assign w_accept = i_valid && !o_stall;

    sop_core #(
        .MAX_STAMP_BYTES   (MAX_STAMP_BYTES),
        .MAX_KID_BYTES     (MAX_KID_BYTES),
        .MAX_CONTEXT_BYTES (MAX_CONTEXT_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_data_byte  (r_data_byte),
        .i_present    (r_present),
        .i_last_byte  (r_last_byte),
        .i_message_id (r_message_id),
        .i_is_request (r_is_request),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_byte  <= i_data_byte;
            r_present    <= i_present;
            r_last_byte  <= i_last_byte;
            r_message_id <= i_message_id;
            r_is_request <= i_is_request;
        end
    end

    // Drop bytes that produce no result; hold a stalled result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_res;
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_byte_kind             = r_res.byte_kind;
    assign o_out_byte              = r_res.out_byte;
    assign o_done_res              = r_res.done_res;
    assign o_ok                    = r_res.ok;
    assign o_ts_present            = r_res.ts_present;
    assign o_resync_request        = r_res.resync_request;
    assign o_phase                 = r_res.phase;
    assign o_corresponding_tx_time = r_res.corresponding_tx_time;
    assign o_receive_time          = r_res.receive_time;
    assign o_transmit_time         = r_res.transmit_time;
    assign o_e2e_id                = r_res.e2e_id;
    assign o_context_length        = r_res.context_length;

endmodule
